>>> rtl/dppt_pkg.sv
// Types and constants shared by the progress timer and its checker.
`timescale 1ns / 1ps
package dppt_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PROG_W    = 17;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [PROG_W-1:0] Q_ONE = PROG_W'(65536);

  localparam logic [TIME_W-1:0] DURATION_RESET = TIME_W'(1000000);
  localparam logic [TIME_W-1:0] DELAY_RESET    = '0;

  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY    = 1'b1;

  typedef enum logic [1:0] {
    FN_UPDATE = 2'd0,
    FN_PAUSE  = 2'd1,
    FN_RESUME = 2'd2,
    FN_RESET  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    PH_PENDING = 3'd0,
    PH_DELAYED = 3'd1,
    PH_RUNNING = 3'd2,
    PH_PAUSED  = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef struct packed {
    func_t             func;
    logic [TIME_W-1:0] time_us;
  } cmd_t;

  typedef struct packed {
    logic [PROG_W-1:0] progress;
    phase_t            phase;
    logic              first_running;
  } res_t;

endpackage

>>> rtl/delayed_pausable_progress_timer.sv
// Delayed, pausable linear progress timer with a bit-serial progress divider.
//
// Usage: each beat on the cmd channel (cmd_valid / cmd_stall) carries a command
// (update, pause, resume, reset) and a microsecond timestamp. Each command
// yields exactly one beat on the res channel (res_valid / res_stall) with the
// Q1.16 progress, the phase after the command and the first_running flag.
// duration_us and delay_us are written through cfg_we / cfg_index / cfg_data;
// the user must make them only while the block is idle; the block has no check.
// Flow: a result that needs no division passes the update, elapsed and active
// states on its way to the finish state; a quotient that clamps to one also
// passes the compare state, and a formed progress quotient passes compare and
// divide, where the restoring divider produces one quotient bit per cycle.
// Throughput: one command at a time; cmd_stall stays high from the accepting
// edge until the result is loaded into the output register.
// The output register lets a new command enter while a result is still held.
// When res_stall is high the result holds; a finished command then waits in
// its final state until the output register frees up.
// Reset (rst, synchronous) returns the phase to pending, clears start_time and
// pause_time and restores duration_us = 1000000 and delay_us = 0.
`timescale 1ns / 1ps
module delayed_pausable_progress_timer
  import dppt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_ELAP,
    S_ACT,
    S_CMP,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state;
  logic [TIME_W-1:0] duration;
  logic [TIME_W-1:0] delay;
  phase_t            phase_reg;
  phase_t            phase_before_pause;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] pause_time;
  func_t             func_q;
  logic [TIME_W-1:0] time_q;
  logic [TIME_W-1:0] dt_start;
  logic [TIME_W-1:0] dt_pause;
  logic              first_q;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] rem;
  logic [DIV_STEPS-1:0] quot;
  logic [CNT_W-1:0]  cnt;
  logic [PROG_W-1:0] prog;

  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              div_ge;
  logic [TIME_W-1:0] elap_ref;
  phase_t            fin_phase;
  logic              cmd_beat;

  assign cmd_stall = (state != S_IDLE);
  assign cmd_beat  = cmd_valid && !cmd_stall;

  always_comb begin
    rem_sh   = {rem, 1'b0};
    rem_sub  = rem_sh - {1'b0, duration};
    div_ge   = (rem_sh >= {1'b0, duration});
    elap_ref = (phase_reg == PH_PAUSED) ? pause_time : time_q;
    if (func_q == FN_UPDATE && phase_reg == PH_RUNNING && prog == Q_ONE) begin
      fin_phase = PH_DONE;
    end else begin
      fin_phase = phase_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duration <= DURATION_RESET;
      delay    <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DURATION: duration <= cfg_data;
        CFG_DELAY:    delay    <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      phase_reg          <= PH_PENDING;
      phase_before_pause <= PH_PENDING;
      start_time         <= '0;
      pause_time         <= '0;
      res_valid          <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_beat) begin
            func_q   <= cmd.func;
            time_q   <= cmd.time_us;
            dt_start <= cmd.time_us - start_time;
            dt_pause <= cmd.time_us - pause_time;
            first_q  <= 1'b0;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          case (func_q)
            FN_UPDATE: begin
              case (phase_reg)
                PH_PENDING: begin
                  start_time <= time_q;
                  if (delay != '0) begin
                    phase_reg <= PH_DELAYED;
                  end else begin
                    phase_reg <= PH_RUNNING;
                    first_q   <= 1'b1;
                  end
                end
                PH_DELAYED: begin
                  if (dt_start >= delay) begin
                    phase_reg <= PH_RUNNING;
                    first_q   <= 1'b1;
                  end
                end
                default: ;
              endcase
            end
            FN_PAUSE: begin
              if (phase_reg == PH_DELAYED || phase_reg == PH_RUNNING) begin
                phase_before_pause <= phase_reg;
                phase_reg          <= PH_PAUSED;
                pause_time         <= time_q;
              end
            end
            FN_RESUME: begin
              if (phase_reg == PH_PAUSED) begin
                start_time <= start_time + dt_pause;
                phase_reg  <= phase_before_pause;
              end
            end
            FN_RESET: begin
              start_time <= '0;
              phase_reg  <= PH_PENDING;
            end
            default: ;
          endcase
          state <= S_ELAP;
        end
        S_ELAP: begin
          elapsed <= elap_ref - start_time;
          state   <= S_ACT;
        end
        S_ACT: begin
          if (phase_reg == PH_DONE) begin
            prog  <= Q_ONE;
            state <= S_FIN;
          end else if ((phase_reg != PH_RUNNING && phase_reg != PH_PAUSED) ||
                       elapsed < delay) begin
            prog  <= '0;
            state <= S_FIN;
          end else begin
            rem   <= elapsed - delay;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rem >= duration) begin
            prog  <= Q_ONE;
            state <= S_FIN;
          end else begin
            quot  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= div_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
          quot <= {quot[DIV_STEPS-2:0], div_ge};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            prog  <= {1'b0, quot[DIV_STEPS-2:0], div_ge};
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            phase_reg         <= fin_phase;
            res.progress      <= prog;
            res.phase         <= fin_phase;
            res.first_running <= first_q;
            res_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/dppt_chk.sv
// Port-level checker for the progress timer, bound to the top level.
`timescale 1ns / 1ps
module dppt_chk
  import dppt_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  a_prog_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.progress <= Q_ONE)
    else $error("progress above one");

  a_done_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.phase == PH_DONE |-> res.progress == Q_ONE)
    else $error("done phase without full progress");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.phase == PH_PENDING || res.phase == PH_DELAYED)
      |-> res.progress == '0)
    else $error("progress nonzero before running");

  a_first_run: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.first_running |-> res.phase == PH_RUNNING || res.phase == PH_DONE)
    else $error("first_running outside running");

endmodule

bind delayed_pausable_progress_timer dppt_chk u_dppt_chk (.*);

>>> dv/delayed_pausable_progress_timer_tb.sv
// Self-checking testbench for the delayed, pausable progress timer.
`timescale 1ns / 1ps
module delayed_pausable_progress_timer_tb;
  import dppt_pkg::*;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data  = '0;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd       = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res;

  delayed_pausable_progress_timer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_t cmd_queue [$];
  res_t res_due   [$];
  int   fail_count = 0;

  logic [TIME_W-1:0] dur_us       = DURATION_RESET;
  logic [TIME_W-1:0] dly_us       = DELAY_RESET;
  phase_t            tmr_phase    = PH_PENDING;
  phase_t            tmr_saved    = PH_PENDING;
  logic [TIME_W-1:0] tmr_start    = '0;
  logic [TIME_W-1:0] tmr_pause_at = '0;

  function automatic logic [PROG_W-1:0] progress_at(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] active;
    logic [47:0]       quo;
    if (tmr_phase == PH_DONE) return Q_ONE;
    if (tmr_phase != PH_RUNNING && tmr_phase != PH_PAUSED) return '0;
    elapsed = ((tmr_phase == PH_PAUSED) ? tmr_pause_at : now) - tmr_start;
    if (elapsed < dly_us) return '0;
    if (dur_us == '0) return Q_ONE;
    active = elapsed - dly_us;
    quo = {active, 16'h0000} / {16'h0000, dur_us};
    if (quo > 48'(Q_ONE)) return Q_ONE;
    return quo[PROG_W-1:0];
  endfunction

  function automatic res_t timer_step(cmd_t c);
    res_t              r;
    logic [TIME_W-1:0] since;
    r = '0;
    case (c.func)
      FN_UPDATE: begin
        if (tmr_phase != PH_PAUSED) begin
          if (tmr_phase == PH_PENDING) begin
            tmr_start = c.time_us;
            if (dly_us != '0) begin
              tmr_phase = PH_DELAYED;
            end else begin
              tmr_phase = PH_RUNNING;
              r.first_running = 1'b1;
            end
          end
          since = c.time_us - tmr_start;
          if (tmr_phase == PH_DELAYED && since >= dly_us) begin
            tmr_phase = PH_RUNNING;
            r.first_running = 1'b1;
          end
          r.progress = progress_at(c.time_us);
          if (tmr_phase == PH_RUNNING && r.progress >= Q_ONE) tmr_phase = PH_DONE;
          r.phase = tmr_phase;
          return r;
        end
      end
      FN_PAUSE: begin
        if (tmr_phase == PH_DELAYED || tmr_phase == PH_RUNNING) begin
          tmr_saved    = tmr_phase;
          tmr_phase    = PH_PAUSED;
          tmr_pause_at = c.time_us;
        end
      end
      FN_RESUME: begin
        if (tmr_phase == PH_PAUSED) begin
          tmr_start = tmr_start + (c.time_us - tmr_pause_at);
          tmr_phase = tmr_saved;
        end
      end
      default: begin
        tmr_start = '0;
        tmr_phase = PH_PENDING;
      end
    endcase
    r.progress = progress_at(c.time_us);
    r.phase    = tmr_phase;
    return r;
  endfunction

  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) res_due.push_back(timer_step(cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          cmd <= cmd_queue.pop_front();
          cmd_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  int stall_mode = 0;
  int stall_cnt  = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt  = $urandom_range(64, 256);
      end
      stall_cnt  = stall_cnt - 1;
      stall_tick = stall_tick + 1;
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        2: res_stall <= ($urandom_range(0, 9) < 7);
        default: res_stall <= stall_tick[4];
      endcase
    end
  end

  res_t want;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (res_due.size() == 0) begin
        $error("unexpected result beat: progress %0d phase %0d first_running %0d",
               res.progress, res.phase, res.first_running);
        fail_count++;
      end else begin
        want = res_due.pop_front();
        if (res.progress !== want.progress) begin
          $error("progress: expected %0d, actual %0d", want.progress, res.progress);
          fail_count++;
        end
        if (res.phase !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, res.phase);
          fail_count++;
        end
        if (res.first_running !== want.first_running) begin
          $error("first_running: expected %0d, actual %0d",
                 want.first_running, res.first_running);
          fail_count++;
        end
      end
    end
  end

  task automatic push_cmd(func_t f, logic [TIME_W-1:0] t);
    cmd_t c;
    c.func    = f;
    c.time_us = t;
    cmd_queue.push_back(c);
  endtask

  task automatic drain();
    while (cmd_queue.size() != 0 || cmd_valid || res_due.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DURATION) begin
      dur_us = val;
    end else begin
      dly_us = val;
    end
  endtask

  task automatic set_config(logic [TIME_W-1:0] dur, logic [TIME_W-1:0] dly);
    drain();
    write_reg(CFG_DURATION, dur);
    write_reg(CFG_DELAY, dly);
  endtask

  task automatic queue_session(int n);
    logic [TIME_W-1:0] now;
    logic [63:0]       span;
    int unsigned       pick;
    int unsigned       sel;
    logic [TIME_W-1:0] step;
    cmd_t              c;
    now  = $urandom;
    span = {32'h0, dur_us} + {32'h0, dly_us};
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        c.func    = func_t'($urandom_range(0, 3));
        c.time_us = $urandom;
      end else begin
        if (pick < 62) begin
          c.func = FN_UPDATE;
        end else if (pick < 74) begin
          c.func = FN_PAUSE;
        end else if (pick < 86) begin
          c.func = FN_RESUME;
        end else if (pick < 91) begin
          c.func = FN_RESET;
        end else begin
          c.func = FN_UPDATE;
        end
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          step = '0;
        end else if (sel == 1) begin
          step = $urandom;
        end else begin
          step = $urandom_range(0, span[31:0] / 10 + 1);
        end
        now       = now + step;
        c.time_us = now;
      end
      cmd_queue.push_back(c);
    end
  endtask

  logic [TIME_W-1:0] dur_set [10] = '{32'd1000, 32'd1000, 32'd1, 32'hFFFF_FFFF, 32'd65536,
                                      32'd3, 32'd250000, 32'd0, 32'd7, 32'd100};
  logic [TIME_W-1:0] dly_set [10] = '{32'd0, 32'd400, 32'd2, 32'hFFFF_FFFF, 32'd1,
                                      32'd0, 32'd1000000, 32'd50, 32'd20, 32'hFFFF_FFFF};

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_cmd(FN_UPDATE, 32'd0);
    push_cmd(FN_UPDATE, 32'd500000);
    push_cmd(FN_PAUSE, 32'd600000);
    push_cmd(FN_UPDATE, 32'd900000);
    push_cmd(FN_RESUME, 32'd700000);
    push_cmd(FN_UPDATE, 32'd1700000);
    push_cmd(FN_UPDATE, 32'd1800000);
    push_cmd(FN_PAUSE, 32'd1900000);
    push_cmd(FN_RESUME, 32'd2000000);
    push_cmd(FN_RESET, 32'hFFFF_FFFF);
    push_cmd(FN_PAUSE, 32'd5);
    push_cmd(FN_RESUME, 32'd6);
    push_cmd(FN_UPDATE, 32'hFFFF_FFF0);
    push_cmd(FN_UPDATE, 32'h0000_0010);
    push_cmd(FN_RESET, 32'd0);

    set_config(32'd1, 32'd1000);
    push_cmd(FN_UPDATE, 32'd5);
    push_cmd(FN_UPDATE, 32'd1004);
    push_cmd(FN_PAUSE, 32'd1005);
    push_cmd(FN_RESUME, 32'd2005);
    push_cmd(FN_UPDATE, 32'd2005);
    push_cmd(FN_UPDATE, 32'd2006);

    set_config(32'd0, 32'd0);
    push_cmd(FN_RESET, 32'd100);
    push_cmd(FN_UPDATE, 32'd123);
    push_cmd(FN_UPDATE, 32'hFFFF_FFFF);

    for (int k = 0; k < 10; k++) begin
      set_config(dur_set[k], dly_set[k]);
      push_cmd(FN_RESET, $urandom);
      queue_session(87);
    end
    set_config($urandom_range(1, 5000), $urandom_range(0, 3000));
    push_cmd(FN_RESET, $urandom);
    queue_session(87);
    set_config($urandom, $urandom);
    push_cmd(FN_RESET, $urandom);
    queue_session(87);

    drain();
    if (fail_count == 0) begin
      $display("[delayed_pausable_progress_timer] OK");
    end else begin
      $display("[delayed_pausable_progress_timer] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[delayed_pausable_progress_timer] ERROR");
    $finish;
  end

endmodule
